// ===== sv/bbx_pkg.sv =====
package bbx_pkg;

    localparam int COORD_W = 32;
    localparam int FRAC = 16;
    localparam int TOL_W = 16;
    localparam int T_W = FRAC + 1;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

    localparam logic REG_NULL_TOL = 1'b0;

    localparam logic [1:0] KIND_MOVE = 2'd0;
    localparam logic [1:0] KIND_LINE = 2'd1;
    localparam logic [1:0] KIND_CTRL = 2'd2;
    localparam logic [1:0] KIND_DATA = 2'd3;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_COEF,
        S_SCALE,
        S_PICK,
        S_SQ1,
        S_SQ2,
        S_DISC,
        S_SQRT,
        S_ROOT,
        S_CHECK,
        S_DIV,
        S_LMUL,
        S_LEND,
        S_WIDEN,
        S_AFTER,
        S_NEXT
    } seq_state_t;

    typedef struct packed {
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
        coord_t x2;
        coord_t y2;
        coord_t x3;
        coord_t y3;
    } curve_pts_t;

    typedef struct packed {
        logic             start;
        logic [TOL_W-1:0] tol;
    } seq_ctrl_t;

    typedef struct packed {
        logic   busy;
        logic   done;
        logic   widen_valid;
        coord_t wx;
        coord_t wy;
    } seq_stat_t;

endpackage

// ===== sv/bbx_mul.sv =====
module bbx_mul
    import bbx_pkg::*;
(
    input  logic                clk,
    input  logic signed [33:0]  op_a,
    input  logic signed [30:0]  op_b,
    output logic signed [64:0]  prod
);

    logic signed [64:0] prod_reg;
    logic signed [64:0] prod_next;

    always_comb
    begin
        prod_next = 65'(op_a) * 65'(op_b);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== sv/bbx_seq.sv =====
module bbx_seq
    import bbx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  seq_ctrl_t  ctrl,
    input  curve_pts_t pts_in,
    output seq_stat_t  stat
);

    seq_state_t state_reg, state_next;

    coord_t pts_reg [2][4];
    coord_t pts_next [2][4];
    coord_t w_reg [4];
    coord_t w_next [4];
    logic axis_reg, axis_next;
    logic root_sel_reg, root_sel_next;
    logic quad_reg, quad_next;
    logic eval_axis_reg, eval_axis_next;
    logic signed [35:0] a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic nulla_reg, nulla_next, nullb_reg, nullb_next;
    logic signed [30:0] as_reg, as_next, bs_reg, bs_next, cs_reg, cs_next;
    logic signed [62:0] pp1_reg, pp1_next;
    logic [61:0] rad_reg, rad_next;
    logic [33:0] rem_reg, rem_next;
    logic [30:0] root_reg, root_next;
    logic [4:0] cnt_reg, cnt_next;
    logic signed [33:0] num_reg, num_next;
    logic signed [32:0] den_reg, den_next;
    logic [31:0] dv_reg, dv_next;
    logic [33:0] drem_reg, drem_next;
    logic [T_W-1:0] q_reg, q_next;
    logic [2:0] lstep_reg, lstep_next;
    logic dneg_reg, dneg_next;
    coord_t rx_reg, rx_next, ry_reg, ry_next;

    logic signed [33:0] op_a;
    logic signed [30:0] op_b;
    logic signed [64:0] prod;

    logic signed [35:0] ca, cb, cc;
    logic signed [37:0] a3, b6;
    logic [37:0] a3_mag, b6_mag;
    logic [35:0] ma, mb, mc, mm;
    logic [2:0] sh;
    logic [35:0] sa, sb, sc;
    logic is_quad;
    logic signed [62:0] disc;
    logic [33:0] rem_sh, trial;
    logic sq_ge;
    logic [33:0] nmag;
    logic [32:0] dmag;
    logic chk_bad;
    logic dv_ge;
    logic [33:0] dv_rem;
    logic [1:0] li;
    coord_t lp, lq;
    logic signed [32:0] ld;
    logic [32:0] ld_mag;
    logic [32:0] lprod;
    logic signed [33:0] lres;

    function automatic logic [1:0] lerp_idx(input logic [2:0] k);
        logic [1:0] r;
        case (k)
            3'd0: r = 2'd0;
            3'd1: r = 2'd1;
            3'd2: r = 2'd2;
            3'd3: r = 2'd0;
            3'd4: r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [35:0] mag36(input logic signed [35:0] v);
        return v[35] ? 36'(-v) : 36'(v);
    endfunction

    bbx_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    always_comb
    begin
        ca = -36'(pts_reg[axis_reg][0]) + 36'sd3 * 36'(pts_reg[axis_reg][1])
             - 36'sd3 * 36'(pts_reg[axis_reg][2]) + 36'(pts_reg[axis_reg][3]);
        cb = 36'(pts_reg[axis_reg][0]) - 36'sd2 * 36'(pts_reg[axis_reg][1])
             + 36'(pts_reg[axis_reg][2]);
        cc = 36'(pts_reg[axis_reg][1]) - 36'(pts_reg[axis_reg][0]);
        a3 = 38'(ca) * 38'sd3;
        b6 = 38'(cb) * 38'sd6;
        a3_mag = a3[37] ? 38'(-a3) : 38'(a3);
        b6_mag = b6[37] ? 38'(-b6) : 38'(b6);

        ma = mag36(a_reg);
        mb = mag36(b_reg);
        mc = mag36(c_reg);
        mm = ma;
        if (mb > mm)
        begin
            mm = mb;
        end
        if (mc > mm)
        begin
            mm = mc;
        end
        if (mm[34])
        begin
            sh = 3'd5;
        end
        else if (mm[33])
        begin
            sh = 3'd4;
        end
        else if (mm[32])
        begin
            sh = 3'd3;
        end
        else if (mm[31])
        begin
            sh = 3'd2;
        end
        else if (mm[30])
        begin
            sh = 3'd1;
        end
        else
        begin
            sh = 3'd0;
        end
        sa = ma >> sh;
        sb = mb >> sh;
        sc = mc >> sh;

        is_quad = !nulla_reg && (as_reg != 31'sd0);

        disc = pp1_reg - prod[62:0];

        rem_sh = {rem_reg[31:0], rad_reg[61:60]};
        trial = {1'b0, root_reg, 2'b01};
        sq_ge = rem_sh >= trial;

        nmag = num_reg[33] ? 34'(-num_reg) : 34'(num_reg);
        dmag = den_reg[32] ? 33'(-den_reg) : 33'(den_reg);
        chk_bad = (den_reg == 33'sd0) ||
                  ((num_reg != 34'sd0) &&
                   ((num_reg[33] != den_reg[32]) || (nmag > {1'b0, dmag})));

        dv_ge = drem_reg >= {2'b00, dv_reg};
        dv_rem = dv_ge ? (drem_reg - {2'b00, dv_reg}) : drem_reg;

        li = lerp_idx(lstep_reg);
        lp = w_reg[li];
        lq = w_reg[li + 2'd1];
        ld = 33'(lq) - 33'(lp);
        ld_mag = ld[32] ? 33'(-ld) : 33'(ld);
        lprod = prod[48:16];
        lres = dneg_reg ? (34'(lp) - 34'({1'b0, lprod})) : (34'(lp) + 34'({1'b0, lprod}));

        op_a = '0;
        op_b = '0;
        case (state_reg)
            S_SQ1:
            begin
                op_a = 34'(bs_reg);
                op_b = bs_reg;
            end
            S_SQ2:
            begin
                op_a = 34'(as_reg);
                op_b = cs_reg;
            end
            S_LMUL:
            begin
                op_a = {1'b0, ld_mag};
                op_b = {14'd0, q_reg};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = S_COEF;
                end
            end
            S_COEF:  state_next = S_SCALE;
            S_SCALE: state_next = S_PICK;
            S_PICK:
            begin
                if (is_quad)
                begin
                    state_next = S_SQ1;
                end
                else if (!nullb_reg)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_SQ1: state_next = S_SQ2;
            S_SQ2: state_next = S_DISC;
            S_DISC: state_next = disc[62] ? S_NEXT : S_SQRT;
            S_SQRT:
            begin
                if (cnt_reg == 5'd1)
                begin
                    state_next = S_ROOT;
                end
            end
            S_ROOT:  state_next = S_CHECK;
            S_CHECK: state_next = chk_bad ? S_AFTER : S_DIV;
            S_DIV:
            begin
                if (cnt_reg == 5'd1)
                begin
                    state_next = S_LMUL;
                end
            end
            S_LMUL: state_next = S_LEND;
            S_LEND:
            begin
                if (lstep_reg == 3'd5 && eval_axis_reg)
                begin
                    state_next = S_WIDEN;
                end
                else
                begin
                    state_next = S_LMUL;
                end
            end
            S_WIDEN: state_next = S_AFTER;
            S_AFTER: state_next = (quad_reg && !root_sel_reg) ? S_ROOT : S_NEXT;
            S_NEXT:  state_next = axis_reg ? S_IDLE : S_COEF;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        pts_next = pts_reg;
        w_next = w_reg;
        axis_next = axis_reg;
        root_sel_next = root_sel_reg;
        quad_next = quad_reg;
        eval_axis_next = eval_axis_reg;
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        nulla_next = nulla_reg;
        nullb_next = nullb_reg;
        as_next = as_reg;
        bs_next = bs_reg;
        cs_next = cs_reg;
        pp1_next = pp1_reg;
        rad_next = rad_reg;
        rem_next = rem_reg;
        root_next = root_reg;
        cnt_next = cnt_reg;
        num_next = num_reg;
        den_next = den_reg;
        dv_next = dv_reg;
        drem_next = drem_reg;
        q_next = q_reg;
        lstep_next = lstep_reg;
        dneg_next = dneg_reg;
        rx_next = rx_reg;
        ry_next = ry_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (ctrl.start)
                begin
                    pts_next[0][0] = pts_in.x0;
                    pts_next[0][1] = pts_in.x1;
                    pts_next[0][2] = pts_in.x2;
                    pts_next[0][3] = pts_in.x3;
                    pts_next[1][0] = pts_in.y0;
                    pts_next[1][1] = pts_in.y1;
                    pts_next[1][2] = pts_in.y2;
                    pts_next[1][3] = pts_in.y3;
                    axis_next = 1'b0;
                end
            end
            S_COEF:
            begin
                a_next = ca;
                b_next = cb;
                c_next = cc;
                nulla_next = a3_mag < {22'd0, ctrl.tol};
                nullb_next = b6_mag < {22'd0, ctrl.tol};
            end
            S_SCALE:
            begin
                as_next = a_reg[35] ? -31'(sa) : 31'(sa);
                bs_next = b_reg[35] ? -31'(sb) : 31'(sb);
                cs_next = c_reg[35] ? -31'(sc) : 31'(sc);
            end
            S_PICK:
            begin
                quad_next = is_quad;
                root_sel_next = !is_quad;
                num_next = -34'(cs_reg);
                den_next = {bs_reg[30], bs_reg, 1'b0};
            end
            S_SQ2:
            begin
                pp1_next = prod[62:0];
            end
            S_DISC:
            begin
                rad_next = disc[61:0];
                rem_next = '0;
                root_next = '0;
                cnt_next = 5'd31;
            end
            S_SQRT:
            begin
                rem_next = sq_ge ? (rem_sh - trial) : rem_sh;
                root_next = {root_reg[29:0], sq_ge};
                rad_next = {rad_reg[59:0], 2'b00};
                cnt_next = cnt_reg - 5'd1;
            end
            S_ROOT:
            begin
                num_next = root_sel_reg ? (-34'(bs_reg) - 34'({3'b000, root_reg}))
                                        : (-34'(bs_reg) + 34'({3'b000, root_reg}));
                den_next = 33'(as_reg);
            end
            S_CHECK:
            begin
                dv_next = dmag[31:0];
                drem_next = nmag;
                q_next = '0;
                cnt_next = 5'd17;
            end
            S_DIV:
            begin
                drem_next = {dv_rem[32:0], 1'b0};
                q_next = {q_reg[T_W-2:0], dv_ge};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    eval_axis_next = 1'b0;
                    lstep_next = '0;
                    w_next = pts_reg[0];
                end
            end
            S_LMUL:
            begin
                dneg_next = ld[32];
            end
            S_LEND:
            begin
                if (lstep_reg == 3'd5)
                begin
                    if (!eval_axis_reg)
                    begin
                        rx_next = lres[COORD_W-1:0];
                        eval_axis_next = 1'b1;
                        lstep_next = '0;
                        w_next = pts_reg[1];
                    end
                    else
                    begin
                        ry_next = lres[COORD_W-1:0];
                    end
                end
                else
                begin
                    w_next[li] = lres[COORD_W-1:0];
                    lstep_next = lstep_reg + 3'd1;
                end
            end
            S_AFTER:
            begin
                if (quad_reg && !root_sel_reg)
                begin
                    root_sel_next = 1'b1;
                end
            end
            S_NEXT:
            begin
                axis_next = 1'b1;
                root_sel_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pts_reg <= pts_next;
        w_reg <= w_next;
        axis_reg <= axis_next;
        root_sel_reg <= root_sel_next;
        quad_reg <= quad_next;
        eval_axis_reg <= eval_axis_next;
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        nulla_reg <= nulla_next;
        nullb_reg <= nullb_next;
        as_reg <= as_next;
        bs_reg <= bs_next;
        cs_reg <= cs_next;
        pp1_reg <= pp1_next;
        rad_reg <= rad_next;
        rem_reg <= rem_next;
        root_reg <= root_next;
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        den_reg <= den_next;
        dv_reg <= dv_next;
        drem_reg <= drem_next;
        q_reg <= q_next;
        lstep_reg <= lstep_next;
        dneg_reg <= dneg_next;
        rx_reg <= rx_next;
        ry_reg <= ry_next;
    end

    always_comb
    begin
        stat.busy = state_reg != S_IDLE;
        stat.done = (state_reg == S_NEXT) && axis_reg;
        stat.widen_valid = state_reg == S_WIDEN;
        stat.wx = rx_reg;
        stat.wy = ry_reg;
    end

endmodule

// ===== sv/path_bounding_box_with_bezier_extrema.sv =====
// Channel   Handshake               Payload
// ------    ---------               -------
// element   start / busy            elem_kind, elem_x, elem_y, last_element
// result    done (one-cycle strobe) box_left, box_top, box_width, box_height, malformed
// config    APB write, pready = 1   null_tolerance at byte address 0
//
// Point, control and stray data items leave busy low; the next item need not wait.
// An item that ends a curve holds busy while each axis is solved: the 31-step square root
// for a quadratic axis, the 17-step divider and twelve passes through the shared
// multiplier for each root.
// done is registered through emit_reg after a last item, or once the curve work ends.
// rst_n clears the path state and sets null_tolerance to 1. Results cannot be stalled.
module path_bounding_box_with_bezier_extrema
    import bbx_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          elem_kind,
    input  logic signed [31:0]  elem_x,
    input  logic signed [31:0]  elem_y,
    input  logic                last_element,
    output logic                done,
    output logic signed [31:0]  box_left,
    output logic signed [31:0]  box_top,
    output logic [31:0]         box_width,
    output logic [31:0]         box_height,
    output logic                malformed,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [TOL_W-1:0] tol_reg;
    coord_t lx_reg, lx_next, hx_reg, hx_next, ly_reg, ly_next, hy_reg, hy_next;
    coord_t cx_reg, cx_next, cy_reg, cy_next;
    coord_t c0x_reg, c0x_next, c0y_reg, c0y_next;
    coord_t c1x_reg, c1x_next, c1y_reg, c1y_next;
    coord_t c2x_reg, c2x_next, c2y_reg, c2y_next;
    logic [1:0] phase_reg, phase_next;
    logic started_reg, started_next;
    logic emit_reg, emit_next;
    logic pend_last_reg, pend_last_next;
    logic mal_reg, mal_next;
    logic done_reg;
    coord_t left_reg, top_reg;
    logic [31:0] wid_reg, hgt_reg;
    logic malo_reg;

    logic accept;
    logic launch;
    logic wen;
    coord_t wxv, wyv;
    logic capture;
    logic signed [32:0] dxs, dys;
    seq_ctrl_t ctrl;
    curve_pts_t pts;
    seq_stat_t stat;

    assign accept = start && !busy;
    assign busy = stat.busy;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NULL_TOL) ? {16'd0, tol_reg} : 32'd0;

    always_comb
    begin
        lx_next = lx_reg;
        hx_next = hx_reg;
        ly_next = ly_reg;
        hy_next = hy_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        c0x_next = c0x_reg;
        c0y_next = c0y_reg;
        c1x_next = c1x_reg;
        c1y_next = c1y_reg;
        c2x_next = c2x_reg;
        c2y_next = c2y_reg;
        phase_next = phase_reg;
        started_next = started_reg;
        emit_next = 1'b0;
        pend_last_next = pend_last_reg;
        mal_next = mal_reg;
        launch = 1'b0;
        wen = 1'b0;
        wxv = elem_x;
        wyv = elem_y;
        if (accept)
        begin
            if (!started_reg)
            begin
                lx_next = elem_x;
                hx_next = elem_x;
                ly_next = elem_y;
                hy_next = elem_y;
                cx_next = elem_x;
                cy_next = elem_y;
                phase_next = 2'd0;
                started_next = 1'b1;
            end
            else if (phase_reg == 2'd0)
            begin
                case (elem_kind)
                    KIND_MOVE, KIND_LINE:
                    begin
                        wen = 1'b1;
                        cx_next = elem_x;
                        cy_next = elem_y;
                    end
                    KIND_CTRL:
                    begin
                        c0x_next = cx_reg;
                        c0y_next = cy_reg;
                        c1x_next = elem_x;
                        c1y_next = elem_y;
                        phase_next = 2'd1;
                    end
                    default:
                    begin
                        cx_next = elem_x;
                        cy_next = elem_y;
                    end
                endcase
            end
            else if (phase_reg == 2'd1)
            begin
                c2x_next = elem_x;
                c2y_next = elem_y;
                phase_next = 2'd2;
            end
            else
            begin
                launch = 1'b1;
                wen = 1'b1;
                cx_next = elem_x;
                cy_next = elem_y;
                phase_next = 2'd0;
            end
            if (last_element)
            begin
                mal_next = started_reg && (phase_next != 2'd0) && !launch;
                started_next = 1'b0;
                phase_next = 2'd0;
                if (launch)
                begin
                    pend_last_next = 1'b1;
                end
                else
                begin
                    emit_next = 1'b1;
                end
            end
        end
        else if (stat.widen_valid)
        begin
            wen = 1'b1;
            wxv = stat.wx;
            wyv = stat.wy;
        end
        if (wen)
        begin
            if (wxv < lx_reg)
            begin
                lx_next = wxv;
            end
            if (wxv > hx_reg)
            begin
                hx_next = wxv;
            end
            if (wyv < ly_reg)
            begin
                ly_next = wyv;
            end
            if (wyv > hy_reg)
            begin
                hy_next = wyv;
            end
        end
        capture = emit_reg || (stat.done && pend_last_reg);
        if (stat.done)
        begin
            pend_last_next = 1'b0;
        end
        dxs = 33'(hx_reg) - 33'(lx_reg);
        dys = 33'(hy_reg) - 33'(ly_reg);
    end

    always_comb
    begin
        ctrl.start = launch;
        ctrl.tol = tol_reg;
        pts.x0 = c0x_reg;
        pts.y0 = c0y_reg;
        pts.x1 = c1x_reg;
        pts.y1 = c1y_reg;
        pts.x2 = c2x_reg;
        pts.y2 = c2y_reg;
        pts.x3 = elem_x;
        pts.y3 = elem_y;
    end

    bbx_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .pts_in (pts),
        .stat   (stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
            lx_reg <= '0;
            hx_reg <= '0;
            ly_reg <= '0;
            hy_reg <= '0;
            cx_reg <= '0;
            cy_reg <= '0;
            phase_reg <= 2'd0;
            started_reg <= 1'b0;
            emit_reg <= 1'b0;
            pend_last_reg <= 1'b0;
            mal_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && (paddr[2] == REG_NULL_TOL))
            begin
                tol_reg <= pwdata[TOL_W-1:0];
            end
            lx_reg <= lx_next;
            hx_reg <= hx_next;
            ly_reg <= ly_next;
            hy_reg <= hy_next;
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            phase_reg <= phase_next;
            started_reg <= started_next;
            emit_reg <= emit_next;
            pend_last_reg <= pend_last_next;
            mal_reg <= mal_next;
            done_reg <= capture;
        end
    end

    always_ff @(posedge clk)
    begin
        c0x_reg <= c0x_next;
        c0y_reg <= c0y_next;
        c1x_reg <= c1x_next;
        c1y_reg <= c1y_next;
        c2x_reg <= c2x_next;
        c2y_reg <= c2y_next;
        if (capture)
        begin
            left_reg <= lx_reg;
            top_reg <= ly_reg;
            wid_reg <= dxs[32] ? 32'd0 : dxs[31:0];
            hgt_reg <= dys[32] ? 32'd0 : dys[31:0];
            malo_reg <= emit_reg ? mal_reg : 1'b0;
        end
    end

    assign done = done_reg;
    assign box_left = left_reg;
    assign box_top = top_reg;
    assign box_width = wid_reg;
    assign box_height = hgt_reg;
    assign malformed = malo_reg;

endmodule

// ===== dv/tb_path_bounding_box_with_bezier_extrema.sv =====
module tb_path_bounding_box_with_bezier_extrema;
    import bbx_pkg::*;

    typedef struct {
        logic [1:0]   kind;
        logic [31:0]  x;
        logic [31:0]  y;
        logic         last;
    } elem_t;

    typedef struct {
        logic [31:0] left;
        logic [31:0] top;
        logic [31:0] width;
        logic [31:0] height;
        logic        malformed;
    } box_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         elem_kind;
    logic signed [31:0] elem_x;
    logic signed [31:0] elem_y;
    logic               last_element;
    logic               done;
    logic signed [31:0] box_left;
    logic signed [31:0] box_top;
    logic [31:0]        box_width;
    logic [31:0]        box_height;
    logic               malformed;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    path_bounding_box_with_bezier_extrema u_top (.*);

    elem_t       pending_elems[$];
    box_t        expected_boxes[$];
    int          mismatches;
    int          boxes_seen;
    int          items_sent;
    int          curves_sent;
    int          gap_pct;
    elem_t       sent_elem;
    logic        busy_q;

    // predictor state
    longint      tol;
    longint      lo_x, hi_x, lo_y, hi_y, cur_x, cur_y;
    longint      cpts[6];
    int          phase;
    bit          started;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint lerp(longint p, longint q, longint t);
        longint d;
        longint m;
        longint prod;
        d = q - p;
        m = mag(d);
        prod = (m >>> FRAC) * t + (((m & ((64'd1 << FRAC) - 1)) * t) >>> FRAC);
        return d < 0 ? p - prod : p + prod;
    endfunction

    function automatic longint casteljau(longint p[4], longint t);
        longint a, b, c, d, e;
        a = lerp(p[0], p[1], t);
        b = lerp(p[1], p[2], t);
        c = lerp(p[2], p[3], t);
        d = lerp(a, b, t);
        e = lerp(b, c, t);
        return lerp(d, e, t);
    endfunction

    function automatic void grow(longint x, longint y);
        if (x < lo_x) lo_x = x;
        if (x > hi_x) hi_x = x;
        if (y < lo_y) lo_y = y;
        if (y > hi_y) hi_y = y;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint res;
        longint bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint shrink(longint v, int s);
        longint m;
        m = mag(v) >> s;
        return v < 0 ? -m : m;
    endfunction

    function automatic void test_root(longint num, longint den, longint px[4], longint py[4]);
        longint t;
        if (den == 0) return;
        if (num != 0 && (((num < 0) != (den < 0)) || mag(num) > mag(den))) return;
        t = (mag(num) << FRAC) / mag(den);
        grow(casteljau(px, t), casteljau(py, t));
    endfunction

    function automatic void solve_axis(longint p[4], longint px[4], longint py[4]);
        longint a, b, c, m, as_, bs, cs, disc, r;
        int     s;
        bit     null_a, null_b;
        a = -p[0] + 3 * p[1] - 3 * p[2] + p[3];
        b = p[0] - 2 * p[1] + p[2];
        c = p[1] - p[0];
        null_a = mag(3 * a) < tol;
        null_b = mag(6 * b) < tol;
        m = mag(a);
        if (mag(b) > m) m = mag(b);
        if (mag(c) > m) m = mag(c);
        s = 0;
        while ((m >> s) >= (64'd1 << 30)) s++;
        as_ = shrink(a, s);
        bs = shrink(b, s);
        cs = shrink(c, s);
        if (!null_a && as_ != 0)
        begin
            disc = bs * bs - as_ * cs;
            if (disc >= 0)
            begin
                r = int_sqrt(disc);
                test_root(-bs + r, as_, px, py);
                test_root(-bs - r, as_, px, py);
            end
        end
        else if (!null_b)
            test_root(-cs, 2 * bs, px, py);
    endfunction

    function automatic logic [31:0] span(longint lo, longint hi);
        longint d;
        d = hi - lo;
        if (d < 0) return 32'd0;
        if (d > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
        return d[31:0];
    endfunction

    function automatic void predict_box(elem_t e);
        longint x, y;
        longint px[4], py[4];
        box_t   b;
        x = longint'(signed'(e.x));
        y = longint'(signed'(e.y));
        if (!started)
        begin
            lo_x = x; hi_x = x; lo_y = y; hi_y = y;
            cur_x = x; cur_y = y;
            phase = 0;
            started = 1'b1;
        end
        else if (phase == 0)
        begin
            if (e.kind == KIND_MOVE || e.kind == KIND_LINE)
            begin
                grow(x, y);
                cur_x = x; cur_y = y;
            end
            else if (e.kind == KIND_CTRL)
            begin
                cpts[0] = cur_x; cpts[1] = cur_y; cpts[2] = x; cpts[3] = y;
                phase = 1;
            end
            else
            begin
                cur_x = x; cur_y = y;
            end
        end
        else if (phase == 1)
        begin
            cpts[4] = x; cpts[5] = y;
            phase = 2;
        end
        else
        begin
            px = '{cpts[0], cpts[2], cpts[4], x};
            py = '{cpts[1], cpts[3], cpts[5], y};
            grow(x, y);
            solve_axis(px, px, py);
            solve_axis(py, px, py);
            cur_x = x; cur_y = y;
            phase = 0;
        end
        if (e.last)
        begin
            b.left = lo_x[31:0];
            b.top = lo_y[31:0];
            b.width = span(lo_x, hi_x);
            b.height = span(lo_y, hi_y);
            b.malformed = phase != 0;
            expected_boxes.insert(expected_boxes.size(), b);
            started = 1'b0;
            phase = 0;
        end
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        mismatches++;
    endtask

    // driver: after each accepted item a new one is presented unless a random gap is drawn
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy_q)
            begin
                predict_box(sent_elem);
                items_sent++;
            end
            if (!(start && busy_q) && pending_elems.size() > 0
                && $urandom_range(99) >= gap_pct)
            begin
                sent_elem = pending_elems.pop_front();
                elem_kind <= sent_elem.kind;
                elem_x <= sent_elem.x;
                elem_y <= sent_elem.y;
                last_element <= sent_elem.last;
                start <= 1'b1;
            end
            else if (!(start && busy_q))
                start <= 1'b0;
        end
    end

    // sample busy at the rising edge so acceptance is judged as the block does
    always @(posedge clk)
        busy_q <= busy;

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            box_t w;
            boxes_seen++;
            if (expected_boxes.size() == 0)
            begin
                report("unexpected result", box_left, 32'd0);
            end
            else
            begin
                w = expected_boxes.pop_front();
                if (box_left !== w.left) report("left", box_left, w.left);
                if (box_top !== w.top) report("top", box_top, w.top);
                if (box_width !== w.width) report("width", box_width, w.width);
                if (box_height !== w.height) report("height", box_height, w.height);
                if (malformed !== w.malformed) report("malformed", malformed, w.malformed);
            end
        end
    end

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'(signed'($urandom_range(2000)) - 1000) <<< 8;
            2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'(int'($urandom_range(200000)) - 100000) <<< 6;
        endcase
    endfunction

    function automatic void queue_elem(logic [1:0] k, logic [31:0] x, logic [31:0] y,
                                       logic l);
        elem_t e;
        e.kind = k; e.x = x; e.y = y; e.last = l;
        pending_elems.insert(pending_elems.size(), e);
    endfunction

    function automatic void queue_path(int n);
        int i;
        logic [1:0] k;
        queue_elem(KIND_MOVE, rnd_coord(), rnd_coord(), n == 1);
        i = 1;
        while (i < n)
        begin
            if ($urandom_range(9) == 0)
                k = 2'($urandom);
            else
                k = $urandom_range(1) ? KIND_CTRL : KIND_LINE;
            if (k == KIND_CTRL && i + 3 <= n && $urandom_range(7) != 0)
            begin
                queue_elem(KIND_CTRL, rnd_coord(), rnd_coord(), 1'b0);
                queue_elem(KIND_DATA, rnd_coord(), rnd_coord(), 1'b0);
                queue_elem(KIND_DATA, rnd_coord(), rnd_coord(), i + 3 == n);
                curves_sent++;
                i += 3;
            end
            else
            begin
                queue_elem(k, rnd_coord(), rnd_coord(), i + 1 == n);
                i++;
            end
        end
    endfunction

    task automatic apb_write(logic [15:0] v);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {REG_NULL_TOL, 2'b00}; pwdata <= {16'd0, v};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        tol = v;
    endtask

    task automatic drain();
        while (pending_elems.size() > 0 || start || busy || expected_boxes.size() > 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    initial
    begin
        int phase_i;
        logic [15:0] tols[4];
        rst_n = 1'b0; start = 1'b0; elem_kind = '0; elem_x = '0; elem_y = '0;
        last_element = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        paddr = '0; pwdata = '0;
        mismatches = 0; boxes_seen = 0; items_sent = 0; curves_sent = 0;
        tol = TOL_RESET; started = 1'b0; phase = 0; gap_pct = 0;
        lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0; cur_x = 0; cur_y = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: single point, extremes, stray data, curves, broken curve
        queue_elem(KIND_LINE, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        queue_elem(KIND_MOVE, 32'h8000_0000, 32'h8000_0000, 1'b0);
        queue_elem(KIND_LINE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        queue_elem(KIND_MOVE, 32'h0, 32'h0, 1'b0);
        queue_elem(KIND_DATA, 32'h0005_0000, 32'hFFFB_0000, 1'b0);
        queue_elem(KIND_CTRL, 32'h0000_0000, 32'h000A_0000, 1'b0);
        queue_elem(KIND_DATA, 32'h000A_0000, 32'h000A_0000, 1'b0);
        queue_elem(KIND_DATA, 32'h000A_0000, 32'h0000_0000, 1'b1);
        queue_elem(KIND_MOVE, 32'h0, 32'h0, 1'b0);
        queue_elem(KIND_CTRL, 32'h0001_0000, 32'h0001_0000, 1'b0);
        queue_elem(KIND_LINE, 32'h0002_0000, 32'h0002_0000, 1'b0);
        queue_elem(KIND_MOVE, 32'h0003_0000, 32'h0003_0000, 1'b1);
        queue_elem(KIND_MOVE, 32'h0, 32'h0, 1'b0);
        queue_elem(KIND_CTRL, 32'h0001_0000, 32'h0, 1'b0);
        queue_elem(KIND_DATA, 32'h0002_0000, 32'h0, 1'b1);
        queue_elem(KIND_MOVE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        queue_elem(KIND_CTRL, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        queue_elem(KIND_DATA, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        queue_elem(KIND_DATA, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        drain();

        tols = '{16'd0, 16'hFFFF, 16'd300, 16'd1};
        for (phase_i = 0; phase_i < 4; phase_i++)
        begin
            apb_write(tols[phase_i]);
            gap_pct = phase_i == 0 ? 33 : (phase_i == 1 ? 62 : 0);
            while (pending_elems.size() < 260)
                queue_path($urandom_range(1, 10));
            drain();
        end

        $display("sent %0d items with %0d full curves, checked %0d boxes",
                 items_sent, curves_sent, boxes_seen);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/bbx_pkg.sv
sv/bbx_mul.sv
sv/bbx_seq.sv
sv/path_bounding_box_with_bezier_extrema.sv
dv/tb_path_bounding_box_with_bezier_extrema.sv
